// ===== sv/clle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clle_pkg
// Shared types and codes for the cursor linked-list engine.
// ----------------------------------------------------------------------------
package clle_pkg;

  // operation codes
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_SETF   = 3'd1;
  localparam logic [2:0] OP_INSA   = 3'd2;
  localparam logic [2:0] OP_INSB   = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;
  localparam logic [2:0] OP_FIND   = 3'd5;
  localparam logic [2:0] OP_STEP   = 3'd6;
  localparam logic [2:0] OP_REWIND = 3'd7;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTEMPTY = 2'd1;
  localparam logic [1:0] ST_NOCUR    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_ALLOC, S_APOP, S_AFIN, S_IA_LINK, S_IA_CUR,
    S_PRD, S_PCHK, S_REM_NX, S_REM_HEAD, S_REM_FREE, S_STEP,
    S_FRD, S_FCHK, S_FEND, S_RDCUR, S_OUT
  } ctl_state_t;

  typedef enum logic [4:0] {
    C_NONE, C_LOAD, C_STATUS, C_CLEAR, C_REWIND, C_RD_RFL, C_ALLOC_FRESH,
    C_ALLOC_POP, C_SETF_FIN, C_RD_CURLNK, C_IA_NEW, C_IA_CUR, C_IB_HEAD,
    C_IB_LINK, C_RD_PLNK, C_P_ADV, C_PRED_FIX, C_REM_NX, C_REM_HEAD,
    C_REM_FREE, C_STEP_FIN, C_WALK_START, C_RD_P, C_F_STEP, C_F_END, C_EMIT
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t    cmd;
    logic [1:0] st;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       cur_v;
    logic       head_v;
    logic       head_is_cur;
    logic       full;
    logic       rfl_v;
    logic       p_v;
    logic       pred_hit;
    logic       walk_more;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== sv/cursor_linked_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_linked_list_engine
// Singly linked list with a cursor, kept in node RAMs with a free list.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. Find and insert-before / remove off
// the head walk the list through the link RAM's registered read port, one
// node per cycle. A stall on the result side holds an operation back only
// while the previous result still waits in the output register. After reset
// and after a clear, nodes are handed out from the recycled free list when it
// holds any and otherwise from a fill counter, so no clearing pass is needed.
// A finished result waits in an output register while the next operation is
// accepted.
module cursor_linked_list_engine #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_operation,
  input  logic [31:0]       in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic              out_found,
  output logic [31:0]       out_current_value,
  output logic              out_current_valid,
  output logic signed [5:0] out_current_position,
  output logic              out_list_empty
);
  import clle_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  clle_ctl u_ctl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  clle_dp #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_operation(in_operation), .in_value(in_value),
    .cmd(cmd), .stat(stat), .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_found(out_found),
    .out_current_value(out_current_value),
    .out_current_valid(out_current_valid),
    .out_current_position(out_current_position),
    .list_empty_o(out_list_empty)
  );

endmodule

// ===== sv/clle_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/clle_ctl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clle_ctl
// Sequencer: walks each operation through datapath micro-steps.
// ----------------------------------------------------------------------------
module clle_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clle_pkg::dp_stat_t  stat,
  output clle_pkg::ctl_cmd_t  cmd
);
  import clle_pkg::*;

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        case (stat.op)
          OP_SETF:   state_nxt = (stat.head_v || stat.full) ? S_RDCUR : S_ALLOC;
          OP_INSA, OP_INSB:
                     state_nxt = (!stat.cur_v || stat.full) ? S_RDCUR : S_ALLOC;
          OP_REMOVE: state_nxt = stat.cur_v ? S_REM_NX : S_RDCUR;
          OP_FIND:   state_nxt = S_FRD;
          OP_STEP:   state_nxt = stat.cur_v ? S_STEP : S_RDCUR;
          default:   state_nxt = S_RDCUR;
        endcase
      end
      S_ALLOC:    state_nxt = stat.rfl_v ? S_APOP : S_AFIN;
      S_APOP:     state_nxt = S_AFIN;
      S_AFIN: begin
        case (stat.op)
          OP_INSA: state_nxt = S_IA_LINK;
          OP_INSB: state_nxt = stat.head_is_cur ? S_RDCUR : S_PRD;
          default: state_nxt = S_RDCUR;
        endcase
      end
      S_IA_LINK:  state_nxt = S_IA_CUR;
      S_IA_CUR:   state_nxt = S_RDCUR;
      S_PRD:      state_nxt = S_PCHK;
      S_PCHK: begin
        if (stat.pred_hit) begin
          state_nxt = (stat.op == OP_REMOVE) ? S_REM_FREE : S_RDCUR;
        end
      end
      S_REM_NX:   state_nxt = stat.head_is_cur ? S_REM_HEAD : S_PRD;
      S_REM_HEAD: state_nxt = S_REM_FREE;
      S_REM_FREE: state_nxt = S_RDCUR;
      S_STEP:     state_nxt = S_RDCUR;
      S_FRD:      state_nxt = stat.p_v ? S_FCHK : S_FEND;
      S_FCHK:     if (!stat.walk_more) state_nxt = S_FEND;
      S_FEND:     state_nxt = S_RDCUR;
      S_RDCUR:    state_nxt = S_OUT;
      S_OUT:      if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd.cmd  = C_NONE;
    cmd.st   = ST_OK;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: if (in_valid) cmd.cmd = C_LOAD;
      S_DISP: begin
        case (stat.op)
          OP_CLEAR: cmd.cmd = C_CLEAR;
          OP_SETF: begin
            if (stat.head_v) begin
              cmd.cmd = C_STATUS;
              cmd.st  = ST_NOTEMPTY;
            end else if (stat.full) begin
              cmd.cmd = C_STATUS;
              cmd.st  = ST_FULL;
            end
          end
          OP_INSA, OP_INSB: begin
            if (!stat.cur_v) begin
              cmd.cmd = C_STATUS;
              cmd.st  = ST_NOCUR;
            end else if (stat.full) begin
              cmd.cmd = C_STATUS;
              cmd.st  = ST_FULL;
            end
          end
          OP_REMOVE: begin
            if (stat.cur_v) begin
              cmd.cmd = C_RD_CURLNK;
            end else begin
              cmd.cmd = C_STATUS;
              cmd.st  = ST_NOCUR;
            end
          end
          OP_FIND:   cmd.cmd = C_WALK_START;
          OP_STEP:   if (stat.cur_v) cmd.cmd = C_RD_CURLNK;
          OP_REWIND: cmd.cmd = C_REWIND;
          default:   cmd.cmd = C_NONE;
        endcase
      end
      S_ALLOC:   cmd.cmd = stat.rfl_v ? C_RD_RFL : C_ALLOC_FRESH;
      S_APOP:    cmd.cmd = C_ALLOC_POP;
      S_AFIN: begin
        case (stat.op)
          OP_SETF: cmd.cmd = C_SETF_FIN;
          OP_INSA: cmd.cmd = C_RD_CURLNK;
          OP_INSB: cmd.cmd = stat.head_is_cur ? C_IB_HEAD : C_IB_LINK;
          default: cmd.cmd = C_NONE;
        endcase
      end
      S_IA_LINK:  cmd.cmd = C_IA_NEW;
      S_IA_CUR:   cmd.cmd = C_IA_CUR;
      S_PRD:      cmd.cmd = C_RD_PLNK;
      S_PCHK:     cmd.cmd = stat.pred_hit ? C_PRED_FIX : C_P_ADV;
      S_REM_NX:   cmd.cmd = C_REM_NX;
      S_REM_HEAD: cmd.cmd = C_REM_HEAD;
      S_REM_FREE: cmd.cmd = C_REM_FREE;
      S_STEP:     cmd.cmd = C_STEP_FIN;
      S_FRD:      if (stat.p_v) cmd.cmd = C_RD_P;
      S_FCHK:     cmd.cmd = C_F_STEP;
      S_FEND:     cmd.cmd = C_F_END;
      S_OUT:      if (stat.out_free) cmd.cmd = C_EMIT;
      default:    cmd.cmd = C_NONE;
    endcase
  end

endmodule

// ===== sv/clle_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clle_dp
// Datapath: node stores, list pointers, walk registers and result register.
// ----------------------------------------------------------------------------
module clle_dp #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_operation,
  input  logic [31:0]        in_value,
  input  clle_pkg::ctl_cmd_t cmd,
  output clle_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [31:0]        out_current_value,
  output logic               out_current_valid,
  output logic signed [5:0]  out_current_position,
  output logic               list_empty_o
);
  import clle_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // pointers carry a valid bit on top of the node index
  logic [AW:0]         head_r, head_nxt, cur_r, cur_nxt, rfl_r, rfl_nxt;
  logic [AW:0]         p_r, p_nxt, nx_r, nx_nxt;
  logic [AW-1:0]       newn_r, newn_nxt;
  logic [CW-1:0]       pos_r, pos_nxt, cnt_r, cnt_nxt, fresh_r, fresh_nxt;
  logic [CW-1:0]       i_r, i_nxt, aft_i_r, aft_i_nxt, bef_i_r, bef_i_nxt;
  logic [AW-1:0]       aft_n_r, aft_n_nxt, bef_n_r, bef_n_nxt;
  logic                has_aft_r, has_aft_nxt, has_bef_r, has_bef_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [1:0]          st_r, st_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          o_st_r, o_st_nxt;
  logic                o_found_r, o_found_nxt;
  logic [31:0]         o_val_r, o_val_nxt;
  logic                o_cv_r, o_cv_nxt;
  logic [5:0]          o_pos_r, o_pos_nxt;
  logic                o_emp_r, o_emp_nxt;

  // memory ports
  logic                  v_we, l_we;
  logic [AW-1:0]         v_waddr, l_waddr, v_raddr, l_raddr;
  logic [DATA_WIDTH-1:0] v_wdata, v_rdata;
  logic [AW:0]           l_wdata, l_rdata;

  logic [63:0]           in_ext, rd_ext;
  logic [31:0]           pos_ext;
  logic                  match, is_aft, is_bef, hit_aft;

  clle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  clle_ram #(.WIDTH(AW + 1), .DEPTH(CAPACITY)) u_lnk_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  assign in_ext  = 64'(in_value);
  assign rd_ext  = 64'(v_rdata);
  assign pos_ext = 32'(pos_r);
  assign match   = (v_rdata == val_r);
  assign is_aft  = !cur_r[AW] || (i_r > pos_r);
  assign is_bef  = cur_r[AW] && (i_r < pos_r);
  assign hit_aft = match && is_aft && !has_aft_r;

  // status toward the sequencer
  always_comb begin
    stat.op          = op_r;
    stat.cur_v       = cur_r[AW];
    stat.head_v      = head_r[AW];
    stat.head_is_cur = head_r[AW] && (head_r[AW-1:0] == cur_r[AW-1:0]);
    stat.full        = (cnt_r == CAP_C);
    stat.rfl_v       = rfl_r[AW];
    stat.p_v         = p_r[AW];
    stat.pred_hit    = (l_rdata == {1'b1, cur_r[AW-1:0]});
    stat.walk_more   = l_rdata[AW] && !has_aft_r && !hit_aft;
    stat.out_free    = !out_valid_r || !out_stall;
  end

  // micro-step execution
  always_comb begin
    head_nxt = head_r;  cur_nxt = cur_r;   rfl_nxt = rfl_r;
    p_nxt = p_r;        nx_nxt = nx_r;     newn_nxt = newn_r;
    pos_nxt = pos_r;    cnt_nxt = cnt_r;   fresh_nxt = fresh_r;
    i_nxt = i_r;        aft_i_nxt = aft_i_r; bef_i_nxt = bef_i_r;
    aft_n_nxt = aft_n_r; bef_n_nxt = bef_n_r;
    has_aft_nxt = has_aft_r; has_bef_nxt = has_bef_r;
    op_nxt = op_r;      val_nxt = val_r;   st_nxt = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_st_nxt = o_st_r;  o_found_nxt = o_found_r; o_val_nxt = o_val_r;
    o_cv_nxt = o_cv_r;  o_pos_nxt = o_pos_r; o_emp_nxt = o_emp_r;
    v_we = 1'b0;        v_waddr = fresh_r[AW-1:0]; v_wdata = val_r;
    l_we = 1'b0;        l_waddr = newn_r;  l_wdata = '0;
    v_raddr = cur_r[AW-1:0];
    l_raddr = cur_r[AW-1:0];
    case (cmd.cmd)
      C_LOAD: begin
        op_nxt  = in_operation;
        val_nxt = in_ext[DATA_WIDTH-1:0];
        st_nxt  = ST_OK;
      end
      C_STATUS: st_nxt = cmd.st;
      C_CLEAR: begin
        head_nxt = '0; cur_nxt = '0; rfl_nxt = '0;
        cnt_nxt = '0;  fresh_nxt = '0;
      end
      C_REWIND: begin
        cur_nxt = head_r;
        pos_nxt = '0;
      end
      C_RD_RFL: l_raddr = rfl_r[AW-1:0];
      C_ALLOC_FRESH: begin
        newn_nxt  = fresh_r[AW-1:0];
        fresh_nxt = fresh_r + 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        v_we      = 1'b1;
      end
      C_ALLOC_POP: begin
        newn_nxt = rfl_r[AW-1:0];
        rfl_nxt  = l_rdata;
        cnt_nxt  = cnt_r + 1'b1;
        v_we     = 1'b1;
        v_waddr  = rfl_r[AW-1:0];
      end
      C_SETF_FIN: begin
        l_we     = 1'b1;
        head_nxt = {1'b1, newn_r};
        cur_nxt  = {1'b1, newn_r};
        pos_nxt  = '0;
      end
      C_IA_NEW: begin
        l_we    = 1'b1;
        l_wdata = l_rdata;
      end
      C_IA_CUR: begin
        l_we    = 1'b1;
        l_waddr = cur_r[AW-1:0];
        l_wdata = {1'b1, newn_r};
      end
      C_IB_HEAD: begin
        l_we     = 1'b1;
        l_wdata  = {1'b1, cur_r[AW-1:0]};
        head_nxt = {1'b1, newn_r};
        pos_nxt  = pos_r + 1'b1;
      end
      C_IB_LINK: begin
        l_we    = 1'b1;
        l_wdata = {1'b1, cur_r[AW-1:0]};
        pos_nxt = pos_r + 1'b1;
        p_nxt   = head_r;
      end
      C_RD_PLNK: l_raddr = p_r[AW-1:0];
      C_P_ADV: begin
        p_nxt   = l_rdata;
        l_raddr = l_rdata[AW-1:0];
      end
      C_PRED_FIX: begin
        l_we    = 1'b1;
        l_waddr = p_r[AW-1:0];
        l_wdata = (op_r == OP_REMOVE) ? nx_r : {1'b1, newn_r};
      end
      C_REM_NX: begin
        nx_nxt = l_rdata;
        p_nxt  = head_r;
      end
      C_REM_HEAD: head_nxt = nx_r;
      C_REM_FREE: begin
        l_we    = 1'b1;
        l_waddr = cur_r[AW-1:0];
        l_wdata = rfl_r;
        rfl_nxt = {1'b1, cur_r[AW-1:0]};
        cnt_nxt = cnt_r - 1'b1;
        cur_nxt = nx_r;
      end
      C_STEP_FIN: begin
        if (l_rdata[AW]) begin
          cur_nxt = l_rdata;
          pos_nxt = pos_r + 1'b1;
        end else begin
          cur_nxt = '0;
        end
      end
      C_WALK_START: begin
        p_nxt = head_r; i_nxt = '0;
        has_aft_nxt = 1'b0; has_bef_nxt = 1'b0;
      end
      C_RD_P: begin
        v_raddr = p_r[AW-1:0];
        l_raddr = p_r[AW-1:0];
      end
      C_F_STEP: begin
        if (hit_aft) begin
          has_aft_nxt = 1'b1;
          aft_n_nxt   = p_r[AW-1:0];
          aft_i_nxt   = i_r;
        end else if (match && is_bef && !has_bef_r) begin
          has_bef_nxt = 1'b1;
          bef_n_nxt   = p_r[AW-1:0];
          bef_i_nxt   = i_r;
        end
        p_nxt   = l_rdata;
        i_nxt   = i_r + 1'b1;
        v_raddr = l_rdata[AW-1:0];
        l_raddr = l_rdata[AW-1:0];
      end
      C_F_END: begin
        if (has_aft_r) begin
          cur_nxt = {1'b1, aft_n_r};
          pos_nxt = aft_i_r;
        end else if (has_bef_r) begin
          cur_nxt = {1'b1, bef_n_r};
          pos_nxt = bef_i_r;
        end
      end
      C_EMIT: begin
        out_valid_nxt = 1'b1;
        o_st_nxt      = st_r;
        o_cv_nxt      = cur_r[AW];
        o_val_nxt     = cur_r[AW] ? rd_ext[31:0] : '0;
        o_found_nxt   = (op_r == OP_FIND) && cur_r[AW] && match;
        o_pos_nxt     = cur_r[AW] ? pos_ext[5:0] : '1;
        o_emp_nxt     = !head_r[AW];
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; cur_r <= '0; rfl_r <= '0;
      cnt_r <= '0;  fresh_r <= '0; pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt; cur_r <= cur_nxt; rfl_r <= rfl_nxt;
      cnt_r <= cnt_nxt;   fresh_r <= fresh_nxt; pos_r <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    p_r <= p_nxt; nx_r <= nx_nxt; newn_r <= newn_nxt; i_r <= i_nxt;
    aft_i_r <= aft_i_nxt; bef_i_r <= bef_i_nxt;
    aft_n_r <= aft_n_nxt; bef_n_r <= bef_n_nxt;
    has_aft_r <= has_aft_nxt; has_bef_r <= has_bef_nxt;
    op_r <= op_nxt; val_r <= val_nxt; st_r <= st_nxt;
    o_st_r <= o_st_nxt; o_found_r <= o_found_nxt; o_val_r <= o_val_nxt;
    o_cv_r <= o_cv_nxt; o_pos_r <= o_pos_nxt; o_emp_r <= o_emp_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = o_st_r;
  assign out_found            = o_found_r;
  assign out_current_value    = o_val_r;
  assign out_current_valid    = o_cv_r;
  assign out_current_position = $signed(o_pos_r);
  assign list_empty_o         = o_emp_r;

endmodule

// ===== verif/tb_cursor_linked_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cursor_linked_list_engine
// Self-checking bench for the cursor linked-list engine: directed list
// operations, then random sequences, checked against a behavioral list model.
// ----------------------------------------------------------------------------
module tb_cursor_linked_list_engine;
  import clle_pkg::*;

  localparam int CAP = 32;
  localparam int N_RANDOM = 830;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [31:0]       cur_value;
    logic              cur_valid;
    logic signed [5:0] cur_pos;
    logic              empty;
  } list_result_t;

  // --------------------------------------------------------------------------
  // list model and queue of predicted answers
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic [31:0]  vals [CAP];
    int           nxt [CAP];
    bit           nxt_v [CAP];
    int           head, cur, cpos, free_hd, count;
    bit           head_v, cur_v;
    list_result_t pending[$];
    int           errors;

    function void clear_list();
      for (int i = 0; i < CAP; i++) begin
        nxt[i] = i + 1;
        nxt_v[i] = (i + 1) < CAP;
      end
      free_hd = 0; count = 0; head = 0; head_v = 0;
      cur = 0; cur_v = 0; cpos = -1;
    endfunction

    function new();
      for (int i = 0; i < CAP; i++) vals[i] = '0;
      errors = 0;
      clear_list();
    endfunction

    function int alloc(logic [31:0] v);
      int n;
      n = free_hd;
      if (nxt_v[n]) free_hd = nxt[n];
      count++;
      vals[n] = v;
      return n;
    endfunction

    function int pred_of(int t);
      int p;
      p = head;
      for (int k = 0; k < CAP; k++) begin
        if (!nxt_v[p]) break;
        if (nxt[p] == t) return p;
        p = nxt[p];
      end
      return p;
    endfunction

    // apply one accepted operation and queue its answer
    function void note_op(logic [2:0] op, logic [31:0] v);
      list_result_t r;
      int n, c, nx, p, i, an, bn, ai, bi, cp;
      bit nv, pv, ha, hb;
      r = '0;
      case (op)
        OP_CLEAR: clear_list();
        OP_SETF: begin
          if (head_v) r.status = ST_NOTEMPTY;
          else if (count >= CAP) r.status = ST_FULL;
          else begin
            n = alloc(v);
            nxt_v[n] = 0; head = n; head_v = 1; cur = n; cur_v = 1; cpos = 0;
          end
        end
        OP_INSA, OP_INSB: begin
          if (!cur_v) r.status = ST_NOCUR;
          else if (count >= CAP) r.status = ST_FULL;
          else begin
            n = alloc(v);
            if (op == OP_INSA) begin
              nxt[n] = nxt[cur]; nxt_v[n] = nxt_v[cur];
              nxt[cur] = n; nxt_v[cur] = 1;
            end else begin
              nxt[n] = cur; nxt_v[n] = 1;
              if (head_v && head == cur) head = n;
              else begin
                p = pred_of(cur);
                nxt[p] = n; nxt_v[p] = 1;
              end
              cpos++;
            end
          end
        end
        OP_REMOVE: begin
          if (!cur_v) r.status = ST_NOCUR;
          else begin
            c = cur; nv = nxt_v[c]; nx = nxt[c];
            if (head_v && head == c) begin
              head = nx; head_v = nv;
            end else begin
              p = pred_of(c);
              nxt[p] = nx; nxt_v[p] = nv;
            end
            nxt[c] = free_hd; nxt_v[c] = count < CAP; free_hd = c; count--;
            cur = nx; cur_v = nv;
            if (!nv) begin
              cur = 0; cpos = -1;
            end
          end
        end
        OP_FIND: begin
          cp = cur_v ? cpos : -1;
          ha = 0; hb = 0; an = 0; bn = 0; ai = 0; bi = 0;
          p = head; pv = head_v; i = 0;
          while (pv && i < CAP) begin
            if (vals[p] == v) begin
              if (i > cp && !ha) begin
                ha = 1; an = p; ai = i;
              end else if (i < cp && !hb) begin
                hb = 1; bn = p; bi = i;
              end
            end
            pv = nxt_v[p]; p = nxt[p]; i++;
          end
          if (ha) begin
            r.found = 1; cur = an; cpos = ai; cur_v = 1;
          end else if (hb) begin
            r.found = 1; cur = bn; cpos = bi; cur_v = 1;
          end else if (cur_v && vals[cur] == v) r.found = 1;
        end
        OP_STEP: begin
          if (cur_v) begin
            if (nxt_v[cur]) begin
              cur = nxt[cur]; cpos++;
            end else begin
              cur = 0; cur_v = 0; cpos = -1;
            end
          end
        end
        default: begin
          cur = head; cur_v = head_v; cpos = head_v ? 0 : -1;
        end
      endcase
      r.cur_value = cur_v ? vals[cur] : '0;
      r.cur_valid = cur_v;
      r.cur_pos = cur_v ? 6'(cpos) : -6'sd1;
      r.empty = !head_v;
      pending = {pending, r};
    endfunction

    // compare one transfer with the oldest prediction
    function void check_result(list_result_t got);
      list_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.status != got.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status); errors++;
      end
      if (e.found != got.found) begin
        $display("%0t: found exp %0d got %0d", $time, e.found, got.found); errors++;
      end
      if (e.cur_value != got.cur_value) begin
        $display("%0t: value exp %h got %h", $time, e.cur_value, got.cur_value); errors++;
      end
      if (e.cur_valid != got.cur_valid) begin
        $display("%0t: valid exp %0d got %0d", $time, e.cur_valid, got.cur_valid);
        errors++;
      end
      if (e.cur_pos != got.cur_pos) begin
        $display("%0t: position exp %0d got %0d", $time, e.cur_pos, got.cur_pos); errors++;
      end
      if (e.empty != got.empty) begin
        $display("%0t: empty exp %0d got %0d", $time, e.empty, got.empty); errors++;
      end
    endfunction
  endclass

  logic              clk, rst_n;
  logic              in_valid, in_stall;
  logic [2:0]        in_operation;
  logic [31:0]       in_value;
  logic              out_valid, out_stall;
  logic [1:0]        out_status;
  logic              out_found;
  logic [31:0]       out_current_value;
  logic              out_current_valid;
  logic signed [5:0] out_current_position;
  logic              out_list_empty;

  cursor_linked_list_engine u_top (.*);

  list_scoreboard sb;
  bit             stim_done;
  bit             hold_long;
  int             idle_cycles;
  logic [31:0]    used_vals[$];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // drive one operation and wait until it is accepted
  task automatic send_op(logic [2:0] op, logic [31:0] v, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_operation <= op; in_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_op(op, v);
    if (op inside {OP_SETF, OP_INSA, OP_INSB}) used_vals = {used_vals, v};
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return 32'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  // pick an operation weighted toward building and walking the list
  function automatic logic [2:0] pick_op();
    int k;
    k = $urandom_range(0, 99);
    if (k < 2) return OP_CLEAR;
    if (k < 8) return OP_SETF;
    if (k < 30) return OP_INSA;
    if (k < 46) return OP_INSB;
    if (k < 60) return OP_REMOVE;
    if (k < 78) return OP_FIND;
    if (k < 92) return OP_STEP;
    return OP_REWIND;
  endfunction

  // stimulus
  initial begin
    logic [31:0] fv;
    sb = new();
    rst_n = 0; in_valid = 0; in_operation = OP_CLEAR; in_value = '0;
    stim_done = 0; hold_long = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty-list corners, then a short list
    send_op(OP_INSA, 32'h1);
    send_op(OP_REMOVE, 32'h0);
    send_op(OP_STEP, 32'h0);
    send_op(OP_REWIND, 32'h0);
    send_op(OP_FIND, 32'h0);
    send_op(OP_SETF, 32'hFFFF_FFFF);
    send_op(OP_SETF, 32'h5);
    send_op(OP_INSB, 32'h0);
    send_op(OP_INSA, 32'hA5A5_5A5A);
    send_op(OP_FIND, 32'hFFFF_FFFF);
    send_op(OP_FIND, 32'h0);
    send_op(OP_STEP, 32'h0);
    send_op(OP_STEP, 32'h0);
    send_op(OP_STEP, 32'h0);
    send_op(OP_REWIND, 32'h0);
    // fill to capacity, then hit the full case
    for (int i = 0; i < CAP; i++) send_op(OP_INSA, 32'(i), 1);
    send_op(OP_INSB, 32'h1234);
    send_op(OP_FIND, 32'h3);
    send_op(OP_REMOVE, 32'h0);
    send_op(OP_CLEAR, 32'h0);
    // long hold-off on the result side while items keep coming
    hold_long = 1;
    send_op(OP_SETF, 32'h7);
    for (int i = 0; i < 8; i++) send_op(OP_INSB, $urandom(), 1);
    // random sequences
    for (int i = 0; i < N_RANDOM; i++) begin
      fv = pick_value();
      if (used_vals.size() > 0 && $urandom_range(0, 1))
        fv = used_vals[$urandom_range(0, used_vals.size() - 1)];
      send_op(pick_op(), fv);
      if (used_vals.size() > 64) void'(used_vals.pop_front());
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // result side: random stall, plus one long hold-off
  initial begin
    int hold;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        for (int k = 0; k < 300; k++) @(posedge clk);
        hold_long = 0;
      end else if (out_stall) begin
        out_stall <= 0;
      end else if (out_valid) begin
        hold = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
        if (hold > 0) begin
          out_stall <= 1;
          repeat (hold - 1) @(posedge clk);
        end
      end
    end
  end

  // sample transfers at the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_status, out_found, out_current_value, out_current_valid,
                        out_current_position, out_list_empty});
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // finish
  initial begin
    idle_cycles = 0;
    fork
      begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
          $display("RESULT: OK");
        else
          $display("RESULT: ERROR");
        $finish;
      end
      begin
        wait (idle_cycles >= WD_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    join
  end

endmodule

// ===== cursor_linked_list_engine.f =====
sv/clle_pkg.sv
sv/clle_ram.sv
sv/clle_ctl.sv
sv/clle_dp.sv
sv/cursor_linked_list_engine.sv
verif/tb_cursor_linked_list_engine.sv
